>>> design/vac_pkg.sv
// Shared types and constants of the velocity add and clamp block.
package vac_pkg;

   localparam int DATA_W     = 32;
   localparam int WIDE_W     = 64;
   localparam int CAP_W      = 31;
   localparam int TOL_W      = 63;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 63;
   localparam int STEP_W     = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_SPEED = 2'd0,
      CSR_ZERO_TOL  = 2'd1
   } vac_csr_type;

   typedef enum logic {
      OP_SQRT = 1'b0,
      OP_DIV  = 1'b1
   } vac_op_type;

   typedef struct packed {
      logic       start;
      vac_op_type op;
   } vac_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } vac_stat_type;

endpackage

>>> design/vac_root_div.sv
// Shared iterative unit: 64-bit integer square root or 64/32 division with a 32-bit quotient.
module vac_root_div (
   input  logic                        clock,
   input  logic                        reset,
   input  vac_pkg::vac_cmd_type        cmd,
   input  logic [vac_pkg::WIDE_W-1:0]  operand,
   input  logic [vac_pkg::DATA_W-1:0]  divisor,
   output vac_pkg::vac_stat_type       stat,
   output logic [vac_pkg::DATA_W-1:0]  result
);
   import vac_pkg::*;

   logic [35:0]       rem_ff, rem_in, shift_v, trial_v;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] res_ff, res_in, div_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, done_ff, ge;
   vac_op_type        op_ff;

   // One root digit (two operand bits) or one quotient bit per cycle.
   always_comb begin
      if (op_ff == OP_SQRT) begin
         shift_v = {rem_ff[33:0], acc_ff[WIDE_W-1 -: 2]};
         trial_v = {2'b00, res_ff, 2'b01};
         acc_in  = {acc_ff[WIDE_W-3:0], 2'b00};
      end else begin
         shift_v = {rem_ff[34:0], acc_ff[WIDE_W-1]};
         trial_v = {4'b0000, div_ff};
         acc_in  = {acc_ff[WIDE_W-2:0], 1'b0};
      end
      ge     = (shift_v >= trial_v);
      rem_in = ge ? (shift_v - trial_v) : shift_v;
      res_in = {res_ff[DATA_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            op_ff   <= cmd.op;
            cnt_ff  <= '1;
            res_ff  <= '0;
            div_ff  <= divisor;
            if (cmd.op == OP_SQRT) begin
               rem_ff <= '0;
               acc_ff <= operand;
            end else begin
               rem_ff <= {4'b0000, operand[WIDE_W-1:DATA_W]};
               acc_ff <= {operand[DATA_W-1:0], {DATA_W{1'b0}}};
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            acc_ff <= acc_in;
            res_ff <= res_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

>>> design/velocity_add_clamp.sv
// Top level of the velocity add and clamp block.
// The block holds a 2D velocity in signed Q16.16 and takes one delta vector
// per transfer on the req_ channel. The delta is added with saturation per
// component, the squared length is formed exactly in Q32.32 through one shared
// 32x32 multiplier in the states ST_SQX, ST_SQY and ST_SQC, and then tested
// against the flush tolerance and the squared speed cap. An item that needs no
// clamp goes from the test state to the finish step, and the block takes no
// new transfer until an item has left the finish step. An item that is not
// flushed and whose length exceeds the cap runs a 32-step square root and two
// 32-step divisions, one for each component, on a single shared iterative unit
// that resolves one bit or one root digit per cycle. The result sits in an
// output register, so a new input transfer is taken while a finished result
// still waits on rsp_stall; only when that register is still full does the
// next result wait in the finish step. Write max_speed and zero_tolerance
// through the csr_ port only while the block is idle; an index beyond the two
// registers is ignored.
module velocity_add_clamp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [vac_pkg::DATA_W-1:0] req_delta_x,
   input  logic signed [vac_pkg::DATA_W-1:0] req_delta_y,
   input  logic                            req_notify_request,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [vac_pkg::DATA_W-1:0] rsp_velocity_x,
   output logic signed [vac_pkg::DATA_W-1:0] rsp_velocity_y,
   output logic                            rsp_moving,
   output logic                            rsp_notify_raised,
   input  logic                            csr_wr_en,
   input  logic [vac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vac_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SQC, ST_TEST, ST_ROOT,
      ST_MULX, ST_GOX, ST_DIVX, ST_MULY, ST_GOY, ST_DIVY, ST_FIN
   } state_type;

   state_type state_ff;

   logic [CAP_W-1:0]         max_speed_ff;
   logic [TOL_W-1:0]         zero_tol_ff;
   logic signed [DATA_W-1:0] vel_x_ff, vel_y_ff;
   logic                     moving_ff, notify_ff;
   logic [WIDE_W-1:0]        lensq_ff, prod_ff;
   logic [DATA_W-1:0]        len_ff;

   logic                     rsp_valid_ff, rsp_moving_ff, rsp_notify_ff;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_y_ff;

   logic signed [DATA_W:0]   sum_x, sum_y;
   logic signed [DATA_W-1:0] sat_x, sat_y;
   logic [DATA_W-1:0]        mag_x, mag_y, mul_a, mul_b, cap_w, quot, quot_neg;
   logic                     flush, clamp, accept_in, out_free;

   vac_cmd_type              cmd;
   vac_stat_type             stat;
   logic [WIDE_W-1:0]        unit_operand;

   // Saturating add of the delta to the held velocity.
   always_comb begin
      sum_x = {vel_x_ff[DATA_W-1], vel_x_ff} + {req_delta_x[DATA_W-1], req_delta_x};
      sum_y = {vel_y_ff[DATA_W-1], vel_y_ff} + {req_delta_y[DATA_W-1], req_delta_y};
      if (sum_x[DATA_W] != sum_x[DATA_W-1]) begin
         sat_x = sum_x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat_x = sum_x[DATA_W-1:0];
      end
      if (sum_y[DATA_W] != sum_y[DATA_W-1]) begin
         sat_y = sum_y[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat_y = sum_y[DATA_W-1:0];
      end
   end

   // Magnitudes as unsigned words; the most negative value maps to 2^31.
   assign mag_x = vel_x_ff[DATA_W-1] ? (~vel_x_ff + 1'b1) : vel_x_ff;
   assign mag_y = vel_y_ff[DATA_W-1] ? (~vel_y_ff + 1'b1) : vel_y_ff;
   assign cap_w = {1'b0, max_speed_ff};

   // Operand selection for the single shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQX:  begin mul_a = mag_x; mul_b = mag_x; end
         ST_SQY:  begin mul_a = mag_y; mul_b = mag_y; end
         ST_SQC:  begin mul_a = cap_w; mul_b = cap_w; end
         ST_MULX: begin mul_a = mag_x; mul_b = cap_w; end
         ST_MULY: begin mul_a = mag_y; mul_b = cap_w; end
         default: begin mul_a = '0;    mul_b = '0;    end
      endcase
   end

   // In the test state prod_ff holds the squared cap.
   assign flush = (lensq_ff < {1'b0, zero_tol_ff});
   assign clamp = (lensq_ff > prod_ff);

   always_comb begin
      cmd.start    = ((state_ff == ST_TEST) && !flush && clamp)
                     || (state_ff == ST_GOX) || (state_ff == ST_GOY);
      cmd.op       = (state_ff == ST_TEST) ? OP_SQRT : OP_DIV;
      unit_operand = (state_ff == ST_TEST) ? lensq_ff : prod_ff;
   end

   vac_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .operand (unit_operand),
      .divisor (len_ff),
      .stat    (stat),
      .result  (quot)
   );

   assign quot_neg  = ~quot + 1'b1;
   assign accept_in = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      prod_ff <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_speed_ff <= '0;
         zero_tol_ff  <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (vac_csr_type'(csr_index))
               CSR_MAX_SPEED: max_speed_ff <= csr_wdata[CAP_W-1:0];
               CSR_ZERO_TOL:  zero_tol_ff  <= csr_wdata[TOL_W-1:0];
               default:       ;
            endcase
         end
         // In the finish step the output register is either reloaded or held.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  vel_x_ff  <= sat_x;
                  vel_y_ff  <= sat_y;
                  notify_ff <= req_notify_request;
                  state_ff  <= ST_SQX;
               end
            end
            ST_SQX: state_ff <= ST_SQY;
            ST_SQY: begin
               lensq_ff <= prod_ff;
               state_ff <= ST_SQC;
            end
            ST_SQC: begin
               lensq_ff <= lensq_ff + prod_ff;
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               if (flush) begin
                  vel_x_ff  <= '0;
                  vel_y_ff  <= '0;
                  moving_ff <= 1'b0;
                  state_ff  <= ST_FIN;
               end else begin
                  moving_ff <= (max_speed_ff != '0);
                  state_ff  <= clamp ? ST_ROOT : ST_FIN;
               end
            end
            ST_ROOT: begin
               if (stat.done) begin
                  len_ff   <= quot;
                  state_ff <= ST_MULX;
               end
            end
            ST_MULX: state_ff <= ST_GOX;
            ST_GOX:  state_ff <= ST_DIVX;
            ST_DIVX: begin
               if (stat.done) begin
                  vel_x_ff <= vel_x_ff[DATA_W-1] ? quot_neg : quot;
                  state_ff <= ST_MULY;
               end
            end
            ST_MULY: state_ff <= ST_GOY;
            ST_GOY:  state_ff <= ST_DIVY;
            ST_DIVY: begin
               if (stat.done) begin
                  vel_y_ff <= vel_y_ff[DATA_W-1] ? quot_neg : quot;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // The result moves into the output register once it is free.
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_x_ff      <= vel_x_ff;
                  rsp_y_ff      <= vel_y_ff;
                  rsp_moving_ff <= moving_ff;
                  rsp_notify_ff <= notify_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_velocity_x    = rsp_x_ff;
   assign rsp_velocity_y    = rsp_y_ff;
   assign rsp_moving        = rsp_moving_ff;
   assign rsp_notify_raised = rsp_notify_ff;

   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !stat.busy)
      else $error("iterative unit started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> $past(stat.busy))
      else $error("iterative unit finished without running");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result shown outside the finish step");

   a_root_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && stat.done) |=> state_ff == ST_MULX)
      else $error("sequencer missed the end of the root");

endmodule

>>> sim/velocity_add_clamp_test.sv
// Testbench for the velocity add and clamp block.
module velocity_add_clamp_test;
   import vac_pkg::*;

   // The block keeps a 2D velocity and takes one delta per transfer. The
   // testbench holds its own model of that velocity and of both registers,
   // works out each expected result when a transfer is accepted, and checks
   // every result transfer against the oldest expectation in the queue.

   typedef struct {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               moving;
      logic               notify;
   } velocity_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [31:0]     req_delta_x;
   logic signed [31:0]     req_delta_y;
   logic                   req_notify_request;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [31:0]     rsp_velocity_x;
   logic signed [31:0]     rsp_velocity_y;
   logic                   rsp_moving;
   logic                   rsp_notify_raised;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Model state: the velocity kept by the block and its two registers.
   logic signed [31:0]     model_vx;
   logic signed [31:0]     model_vy;
   logic [30:0]            model_cap;
   logic [62:0]            model_tol;

   velocity_result_type    expected_velocities[$];
   int                     error_count;
   longint                 cycle_count;
   bit                     rsp_idle_enable;

   localparam longint CYCLE_LIMIT = 2_000_000;

   velocity_add_clamp dut (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Saturating add of one component.
   function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      logic signed [33:0] s;
      s = 34'(a) + 34'(b);
      if (s > 34'sh07FFFFFFF)
         return 32'sh7FFFFFFF;
      else if (s < -34'sh080000000)
         return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale one component toward zero by cap / len.
   function automatic logic signed [31:0] scaled(logic signed [31:0] v,
                                                 logic [63:0] cap,
                                                 logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = v < 0 ? 64'(-65'(v)) : 64'(v);
      q   = mag * cap / len;
      return v < 0 ? -q[31:0] : q[31:0];
   endfunction

   // Advance the model velocity by one delta and return the result.
   function automatic velocity_result_type apply_delta(logic signed [31:0] dx,
                                                       logic signed [31:0] dy,
                                                       logic nreq);
      velocity_result_type r;
      logic [63:0]      mx;
      logic [63:0]      my;
      logic [63:0]      lensq;
      logic [63:0]      cap;
      logic [63:0]      len;
      model_vx = sat_sum(model_vx, dx);
      model_vy = sat_sum(model_vy, dy);
      mx    = model_vx < 0 ? 64'(-65'(model_vx)) : 64'(model_vx);
      my    = model_vy < 0 ? 64'(-65'(model_vy)) : 64'(model_vy);
      lensq = mx * mx + my * my;
      cap   = 64'(model_cap);
      if (lensq < 64'(model_tol)) begin
         model_vx = 0;
         model_vy = 0;
         r.moving = 1'b0;
      end else begin
         if (lensq > cap * cap) begin
            len      = root_floor(lensq);
            model_vx = scaled(model_vx, cap, len);
            model_vy = scaled(model_vy, cap, len);
         end
         r.moving = model_cap != 0;
      end
      r.vx     = model_vx;
      r.vy     = model_vy;
      r.notify = nreq;
      return r;
   endfunction

   // Input side: predict each accepted transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_velocities.push_back(
            apply_delta(req_delta_x, req_delta_y, req_notify_request));
   end

   // Output side: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      velocity_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_velocities.size() == 0) begin
            $display("%0t: result with none expected: x=%h y=%h", $time,
                     rsp_velocity_x, rsp_velocity_y);
            error_count++;
         end else begin
            e = expected_velocities.pop_front();
            if (rsp_velocity_x !== e.vx) begin
               $display("%0t: velocity_x expected %h actual %h", $time, e.vx,
                        rsp_velocity_x);
               error_count++;
            end
            if (rsp_velocity_y !== e.vy) begin
               $display("%0t: velocity_y expected %h actual %h", $time, e.vy,
                        rsp_velocity_y);
               error_count++;
            end
            if (rsp_moving !== e.moving) begin
               $display("%0t: moving expected %b actual %b", $time, e.moving,
                        rsp_moving);
               error_count++;
            end
            if (rsp_notify_raised !== e.notify) begin
               $display("%0t: notify_raised expected %b actual %b", $time,
                        e.notify, rsp_notify_raised);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls come in random bursts while enabled.
   always @(posedge clock) begin
      int burst;
      if (reset || !rsp_idle_enable) begin
         rsp_stall <= 1'b0;
      end else if (burst > 0) begin
         burst--;
         if (burst == 0)
            rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         burst = $urandom_range(1, 8);
         rsp_stall <= 1'b1;
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Send one delta; waits until the transfer is accepted. Valid then drops,
   // while the block is still busy with the item.
   task automatic send_delta(logic signed [31:0] dx, logic signed [31:0] dy,
                             logic nreq, bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_delta_x        <= dx;
      req_delta_y        <= dy;
      req_notify_request <= nreq;
      do
         @(posedge clock);
      while (req_stall);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every result has arrived, then let any clamp work drain.
   task automatic drain_results();
      while (expected_velocities.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(vac_csr_type idx, logic [62:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAX_SPEED)
         model_cap = value[30:0];
      else if (idx == CSR_ZERO_TOL)
         model_tol = value;
      @(posedge clock);
   endtask

   // An index beyond the two registers must leave both unchanged.
   task automatic write_unused_index();
      csr_wr_en <= 1'b1;
      csr_index <= 2'd3;
      csr_wdata <= '1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_delta();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         2: return 32'($signed($urandom_range(0, 8000))) - 32'sd4000;
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)))
                         - 32'sh0020_0000;
      endcase
   endfunction

   // Extremes and special cases: saturation both ways, the largest cap, zero cap,
   // flushing, the tolerance boundary and a clamp.
   task automatic test_directed();
      write_reg(CSR_MAX_SPEED, 63'h7FFFFFFF);
      write_reg(CSR_ZERO_TOL, 63'd0);
      send_delta(32'sh7FFFFFFF, 32'sh80000000, 1'b1, 0);
      send_delta(32'sh7FFFFFFF, 32'sh80000000, 1'b0, 0);
      send_delta(32'sh80000000, 32'sh7FFFFFFF, 1'b1, 0);
      send_delta(32'sh80000000, 32'sh7FFFFFFF, 1'b0, 0);
      send_delta(32'sh80000000, 32'sh80000000, 1'b1, 0);
      send_delta(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0);
      drain_results();
      // A zero cap drives any nonzero velocity to zero.
      write_reg(CSR_MAX_SPEED, 63'd0);
      send_delta(32'sh00010000, 32'sh00000001, 1'b1, 0);
      send_delta(32'sh0, 32'sh0, 1'b0, 0);
      drain_results();
      // Flush tests: tolerance at its maximum flushes every velocity but the one with both components most negative.
      write_reg(CSR_MAX_SPEED, 63'h0003_0000);
      write_reg(CSR_ZERO_TOL, 63'h7FFFFFFFFFFFFFFF);
      send_delta(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 0);
      drain_results();
      // Squared length equal to the tolerance does not flush.
      write_reg(CSR_ZERO_TOL, 63'd25);
      send_delta(32'sd3, 32'sd4, 1'b0, 0);
      send_delta(-32'sd3, -32'sd5, 1'b1, 0);
      // Length just over 5.0 against a cap of 3.0, then a zero delta on the clamped velocity.
      send_delta(32'sh0003_0000, 32'sh0004_0001, 1'b0, 0);
      send_delta(32'sh0, 32'sh0, 1'b1, 0);
      send_delta(-32'sh0006_0000, 32'sh0, 1'b0, 0);
      drain_results();
      write_unused_index();
      send_delta(32'sh0000_1000, -32'sh0000_1000, 1'b1, 0);
      drain_results();
   endtask

   // Random deltas under one register setting.
   task automatic test_random_phase(int count, logic [62:0] cap,
                                    logic [62:0] tol, bit may_idle);
      write_reg(CSR_MAX_SPEED, cap);
      write_reg(CSR_ZERO_TOL, tol);
      for (int i = 0; i < count; i++) begin
         send_delta(random_delta(), random_delta(), 1'($urandom), may_idle);
         // Hold off once in a while until the block has fully caught up.
         if ($urandom_range(0, 60) == 0)
            while (expected_velocities.size() != 0)
               @(posedge clock);
      end
      drain_results();
   endtask

   task automatic test_random();
      rsp_idle_enable = 1;
      test_random_phase(200, 63'h7FFFFFFF, 63'd0, 1);
      test_random_phase(200, 63'($urandom_range(1, 32'h0080_0000)),
                        {31'd0, 32'($urandom)}, 1);
      test_random_phase(150, 63'd0, 63'd0, 1);
      test_random_phase(200, 63'($urandom_range(32'h0001_0000, 32'h0100_0000)),
                        {$urandom, 31'($urandom)} >> $urandom_range(10, 40), 1);
      test_random_phase(150, 63'd1, 63'h7FFFFFFFFFFFFFFF, 1);
      test_random_phase(150, 63'($urandom), 63'd0, 1);
      // The last stretch runs with no idling on either side.
      rsp_idle_enable = 0;
      test_random_phase(180, 63'($urandom_range(1, 32'h0400_0000)),
                        63'($urandom), 0);
   endtask

   initial begin
      error_count        = 0;
      cycle_count        = 0;
      rsp_idle_enable    = 0;
      model_vx           = 0;
      model_vy           = 0;
      model_cap          = 0;
      model_tol          = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_delta_x        = 0;
      req_delta_y        = 0;
      req_notify_request = 1'b0;
      rsp_stall          = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
design/vac_pkg.sv
design/vac_root_div.sv
design/velocity_add_clamp.sv
sim/velocity_add_clamp_test.sv
